FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the deque, included by circular_deque.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

FILE: hdl/cdq_pkg.sv
// Package with the action and status codes of the circular deque.
`default_nettype none

package cdq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 4;

endpackage

`default_nettype wire

FILE: hdl/circular_deque.sv
// Latency: a result is offered in the cycle after its item is accepted.
// Throughput: one item per cycle; the input stalls only while a result waits
// and the output side stalls, since the single result register must hold it.
// Pointers and count update at acceptance; a pop reads the storage RAM at that
// edge and the registered read word feeds the result directly.
// Reset empties the queue and drops any pending result; the RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"

module circular_deque #(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         action,
    input  wire logic signed [cdq_pkg::DATA_W-1:0]  data_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              status,
    output logic signed [cdq_pkg::DATA_W-1:0]       data_out,
    output logic [cdq_pkg::OCC_W-1:0]               occupancy
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic                              out_valid_reg, out_valid_next;
    cdq_pkg::status_t                  status_reg, status_next;
    logic                              pop_ok_reg, pop_ok_next;
    logic [cdq_pkg::OCC_W-1:0]         occ_reg, occ_next;
    logic [cdq_pkg::DATA_W-1:0]        rdata_reg;

    logic [cdq_pkg::DATA_W-1:0]        mem [DEPTH];

    cdq_pkg::action_t act;
    logic             accept;
    logic             is_push;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    assign act      = cdq_pkg::action_t'(action);
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        unique case (act)
            cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: is_push = 1'b1;
            default:                                         is_push = 1'b0;
        endcase
    end

    // Pointer, count and RAM control for the accepted item.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = cdq_pkg::ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = '0;
        rd_addr     = (act == cdq_pkg::ACT_POP_FRONT) ? head_reg : tail_reg;
        if (is_push)
        begin
            if (full)
            begin
                status_next = cdq_pkg::ST_OVERFLOW;
            end
            else
            begin
                wr_en      = accept;
                count_next = count_reg + CW'(1);
                // The first entry always lands at slot zero, whichever end is named.
                if (empty)
                begin
                    head_next = '0;
                    tail_next = '0;
                    wr_addr   = '0;
                end
                else if (act == cdq_pkg::ACT_PUSH_FRONT)
                begin
                    head_next = idx_dec(head_reg);
                    wr_addr   = head_next;
                end
                else
                begin
                    tail_next = idx_inc(tail_reg);
                    wr_addr   = tail_next;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = cdq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                rd_en       = accept;
                pop_ok_next = 1'b1;
                count_next  = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (act == cdq_pkg::ACT_POP_FRONT)
                begin
                    head_next = idx_inc(head_reg);
                end
                else
                begin
                    tail_next = idx_dec(tail_reg);
                end
            end
        end
    end

    always_comb
    begin
        occ_next       = cdq_pkg::OCC_W'(count_next);
        out_valid_next = accept || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
            occ_reg    <= occ_next;
        end
    end

    // Storage RAM: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= data_in;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;
    assign data_out  = pop_ok_reg ? rdata_reg : '0;

    `ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_SAME(a_empty_home, clk, rst_n, empty, (head_reg == '0) && (tail_reg == '0))
    `ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid_reg)
    `ASSERT_NEXT(a_refused_keeps, clk, rst_n, accept && is_push && full, count_reg == $past(count_reg))

endmodule

`default_nettype wire

FILE: test/tb_circular_deque.sv
// Self-checking testbench for the circular deque, with a scoreboard class and random stimulus.
module tb_circular_deque;

    localparam int unsigned DEPTH        = 8;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned PRESSURE_AT  = 300;

    typedef struct {
        cdq_pkg::status_t                 status;
        logic [cdq_pkg::DATA_W-1:0]       word;
        logic [cdq_pkg::OCC_W-1:0]        occ;
    } deque_result_t;

    class deque_scoreboard #(int unsigned SLOTS = 8);
        logic [cdq_pkg::DATA_W-1:0] slot_words [SLOTS];
        int unsigned                front_idx;
        int unsigned                rear_idx;
        int unsigned                fill;
        deque_result_t              expected_results [$];
        int unsigned                errors;

        function new();
            foreach (slot_words[i])
                slot_words[i] = '0;
            front_idx = 0;
            rear_idx  = 0;
            fill      = 0;
            errors    = 0;
        endfunction

        // Applies one accepted action to the shadow deque and queues its result.
        function void note_transfer(logic [1:0] act, logic [cdq_pkg::DATA_W-1:0] word);
            deque_result_t r;
            int unsigned   slot;
            r.status = cdq_pkg::ST_OK;
            r.word   = '0;
            if (act == cdq_pkg::ACT_PUSH_FRONT || act == cdq_pkg::ACT_PUSH_REAR)
            begin
                if (fill >= SLOTS)
                begin
                    r.status = cdq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    // A push into an empty deque always lands in slot zero.
                    if (fill == 0)
                    begin
                        front_idx = 0;
                        rear_idx  = 0;
                        slot      = 0;
                    end
                    else if (act == cdq_pkg::ACT_PUSH_FRONT)
                    begin
                        front_idx = (front_idx == 0) ? SLOTS - 1 : front_idx - 1;
                        slot      = front_idx;
                    end
                    else
                    begin
                        rear_idx = (rear_idx == SLOTS - 1) ? 0 : rear_idx + 1;
                        slot     = rear_idx;
                    end
                    slot_words[slot] = word;
                    fill++;
                end
            end
            else
            begin
                if (fill == 0)
                begin
                    r.status = cdq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    r.word = slot_words[(act == cdq_pkg::ACT_POP_FRONT) ? front_idx : rear_idx];
                    fill--;
                    if (fill == 0)
                    begin
                        front_idx = 0;
                        rear_idx  = 0;
                    end
                    else if (act == cdq_pkg::ACT_POP_FRONT)
                    begin
                        front_idx = (front_idx == SLOTS - 1) ? 0 : front_idx + 1;
                    end
                    else
                    begin
                        rear_idx = (rear_idx == 0) ? SLOTS - 1 : rear_idx - 1;
                    end
                end
            end
            r.occ = cdq_pkg::OCC_W'(fill);
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [cdq_pkg::DATA_W-1:0] word,
                                   logic [cdq_pkg::OCC_W-1:0] occ);
            deque_result_t r;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d data %h occupancy %0d",
                             st, word, occ);
                return;
            end
            r = expected_results.pop_front();
            if (st !== r.status || word !== r.word || occ !== r.occ)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d data %h/%h occupancy %0d/%0d",
                             r.status, st, r.word, word, r.occ, occ);
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic [1:0]                         action;
    logic signed [cdq_pkg::DATA_W-1:0]  data_in;
    logic                               out_valid;
    logic                               out_stall;
    logic [1:0]                         status;
    logic signed [cdq_pkg::DATA_W-1:0]  data_out;
    logic [cdq_pkg::OCC_W-1:0]          occupancy;

    bit hold_request;

    deque_scoreboard #(DEPTH) sb;

    circular_deque #(.DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .occupancy (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("circular_deque verification failed");
        $finish;
    end

    // Both channels are sampled with the values they held before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_transfer(action, data_in);
            if (out_valid && !out_stall)
                sb.check_result(status, data_out, occupancy);
        end
    end

    // Receiver: quiet stretches, random stalls and periodic stalls, plus one long hold-off.
    initial
    begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mode;
        int unsigned stall_pct;
        int unsigned period;
        int unsigned phase;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        stall_pct = 0;
        period    = 2;
        phase     = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 80);
                    mode      = $urandom_range(0, 2);
                    stall_pct = $urandom_range(10, 70);
                    period    = $urandom_range(2, 5);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < stall_pct);
                    default: out_stall <= (phase % period == 0);
                endcase
            end
        end
    end

    // Holds one transfer on the input channel until the block takes it.
    task automatic offer(input cdq_pkg::action_t act,
                         input logic [cdq_pkg::DATA_W-1:0] word);
        in_valid <= 1'b1;
        action   <= act;
        data_in  <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause(input int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [cdq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::action_t pick_action(input int unsigned push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? cdq_pkg::ACT_PUSH_REAR : cdq_pkg::ACT_PUSH_FRONT;
        return $urandom_range(0, 1) ? cdq_pkg::ACT_POP_REAR : cdq_pkg::ACT_POP_FRONT;
    endfunction

    task automatic run_directed();
        int unsigned k;
        // Pops from the empty deque are refused.
        offer(cdq_pkg::ACT_POP_FRONT, 32'h1234_5678);
        offer(cdq_pkg::ACT_POP_REAR, 32'hFFFF_FFFF);
        // A single entry in and out again, which returns both indices to zero.
        offer(cdq_pkg::ACT_PUSH_REAR, 32'h7FFF_FFFF);
        offer(cdq_pkg::ACT_POP_FRONT, 32'h0000_0000);
        // The second front push wraps the head index below zero.
        offer(cdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        offer(cdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        offer(cdq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
        for (k = 0; k < DEPTH - 3; k++)
            offer(k[0] ? cdq_pkg::ACT_PUSH_REAR : cdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555 ^ k);
        offer(cdq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA);
        offer(cdq_pkg::ACT_PUSH_REAR, 32'h5555_5555);
        for (k = 0; k < DEPTH; k++)
            offer(k[0] ? cdq_pkg::ACT_POP_FRONT : cdq_pkg::ACT_POP_REAR, 32'hAAAA_AAAA);
        offer(cdq_pkg::ACT_PUSH_FRONT, 32'h0000_0001);
        offer(cdq_pkg::ACT_POP_REAR, 32'h0000_0000);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst_left;
        int unsigned seg_left;
        int unsigned push_pct;
        int unsigned wait_cycles;
        hold_request = 1'b0;
        sb = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= cdq_pkg::ACT_PUSH_FRONT;
        data_in  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        sent       = 0;
        burst_left = 0;
        seg_left   = 0;
        push_pct   = 50;
        while (sent < RANDOM_ITEMS)
        begin
            // Each segment leans toward filling, draining or churning the deque.
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 4))
                    0:       push_pct = 95;
                    1:       push_pct = 80;
                    2:       push_pct = 50;
                    3:       push_pct = 20;
                    default: push_pct = 5;
                endcase
            end
            if (sent == PRESSURE_AT)
            begin
                hold_request = 1'b1;
                burst_left   = 40;
            end
            else if (burst_left == 0)
            begin
                pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
            offer(pick_action(push_pct), pick_word());
            burst_left--;
            seg_left--;
            sent++;
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("circular_deque verification clean");
        else
            $display("circular_deque verification failed");
        $finish;
    end

endmodule
